// ===== hw/rtl/fpq_pkg.sv =====
package fpq_pkg;

  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int VAL_W  = 32;
  localparam int PRIO_W = 8;
  localparam int REQ_W  = 2;
  localparam int ST_W   = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_CHANGE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

  // search token passed from cell to cell, one cell per cycle
  typedef struct packed {
    logic                    act;
    logic                    found;
    logic                    have;
    logic [PRIO_W-1:0]       best_prio;
    logic [IDX_W-1:0]        best_idx;
    logic signed [VAL_W-1:0] best_value;
  } wave_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic                    wr;
    logic signed [VAL_W-1:0] wr_value;
    logic [PRIO_W-1:0]       wr_prio;
    logic                    chg;
    logic                    rem;
    logic signed [VAL_W-1:0] key;
    logic [PRIO_W-1:0]       new_prio;
    logic                    shift;
    logic [IDX_W-1:0]        shift_idx;
    logic [CNT_W-1:0]        count;
  } cell_cmd_t;

endpackage

// ===== hw/rtl/fpq_cell.sv =====
module fpq_cell (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [fpq_pkg::IDX_W-1:0]       idx,
  input  fpq_pkg::cell_cmd_t              cmd,
  input  fpq_pkg::wave_t                  wave_in,
  output fpq_pkg::wave_t                  wave_out,
  input  logic signed [fpq_pkg::VAL_W-1:0] nb_value,
  input  logic [fpq_pkg::PRIO_W-1:0]      nb_prio,
  output logic signed [fpq_pkg::VAL_W-1:0] value,
  output logic [fpq_pkg::PRIO_W-1:0]      prio
);
  import fpq_pkg::*;

  logic  live;
  logic  match;
  logic  better;
  wave_t wave_next;

  always_comb begin
    live      = CNT_W'(idx) < cmd.count;
    match     = wave_in.act && cmd.chg && live && !wave_in.found && (value == cmd.key);
    better    = wave_in.act && cmd.rem && live &&
                (!wave_in.have || (prio > wave_in.best_prio));
    wave_next = wave_in;
    if (match) begin
      wave_next.found = 1'b1;
    end
    if (better) begin
      wave_next.have       = 1'b1;
      wave_next.best_prio  = prio;
      wave_next.best_idx   = idx;
      wave_next.best_value = value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_out <= '0;
    end else begin
      wave_out <= wave_next;
    end
  end

  // entry storage: insert at tail, priority update on match, close gap on remove
  always_ff @(posedge clk) begin
    if (cmd.wr && (idx == cmd.count[IDX_W-1:0])) begin
      value <= cmd.wr_value;
      prio  <= cmd.wr_prio;
    end else if (match) begin
      prio <= cmd.new_prio;
    end else if (cmd.shift && (idx >= cmd.shift_idx)) begin
      value <= nb_value;
      prio  <= nb_prio;
    end
  end

endmodule

// ===== hw/rtl/fifo_tie_priority_queue_core.sv =====
// Priority queue of value/priority pairs kept in arrival order in a row of cells.
// Request channel: req_type, item_value, item_priority are taken at a rising edge
// where start is high and busy is low. req_type selects insert, change priority of
// the oldest entry with a matching value, or remove of the highest priority entry
// (oldest wins a tie). Result channel: status and removed_value are shown for one
// cycle with done high; the receiver cannot stall, so each result must be taken then.
// Latency: insert, remove on an empty queue and unused request kinds give done on
// the cycle after the request, and busy stays low, so these run one per cycle.
// Change and remove send a search token down the row of DEPTH cells, one cell per
// cycle; done comes DEPTH + 2 cycles after the request (18 at DEPTH 16) and busy is
// high until the cycle done is shown, so the next request may be taken with done.
// The token walk through the cell row sets that figure. Remove closes the gap in the
// done cycle by shifting every cell above the taken one down by one.
// Reset (rst, synchronous) empties the queue and cancels any search in flight; entry
// storage itself is not cleared.
module fifo_tie_priority_queue_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [fpq_pkg::REQ_W-1:0]        req_type,
  input  logic signed [fpq_pkg::VAL_W-1:0] item_value,
  input  logic [fpq_pkg::PRIO_W-1:0]       item_priority,
  output logic                             done,
  output logic [fpq_pkg::ST_W-1:0]         status,
  output logic signed [fpq_pkg::VAL_W-1:0] removed_value
);
  import fpq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } state_t;

  state_t                  state;
  logic [CNT_W-1:0]        cnt;
  logic                    op_chg;
  logic                    op_rem;
  logic signed [VAL_W-1:0] key;
  logic [PRIO_W-1:0]       new_prio;
  logic                    launch;

  logic                    accept;
  logic                    full;
  logic                    fin;
  wave_t                   wave [DEPTH+1];
  wave_t                   last;
  cell_cmd_t               cmd;
  logic signed [VAL_W-1:0] val [DEPTH];
  logic [PRIO_W-1:0]       pr [DEPTH];

  assign busy   = (state == S_SCAN);
  assign accept = start && !busy;
  assign full   = (cnt >= CNT_W'(DEPTH));
  assign last   = wave[DEPTH];
  assign fin    = last.act;

  always_comb begin
    wave[0]     = '0;
    wave[0].act = launch;
  end

  always_comb begin
    cmd           = '0;
    cmd.wr        = accept && (req_type == REQ_INSERT) && !full;
    cmd.wr_value  = item_value;
    cmd.wr_prio   = item_priority;
    cmd.chg       = op_chg;
    cmd.rem       = op_rem;
    cmd.key       = key;
    cmd.new_prio  = new_prio;
    cmd.shift     = fin && op_rem;
    cmd.shift_idx = last.best_idx;
    cmd.count     = cnt;
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] nbv;
    logic [PRIO_W-1:0]       nbp;
    if (i < DEPTH - 1) begin : g_mid
      assign nbv = val[i+1];
      assign nbp = pr[i+1];
    end else begin : g_end
      assign nbv = val[i];
      assign nbp = pr[i];
    end
    fpq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (IDX_W'(i)),
      .cmd      (cmd),
      .wave_in  (wave[i]),
      .wave_out (wave[i+1]),
      .nb_value (nbv),
      .nb_prio  (nbp),
      .value    (val[i]),
      .prio     (pr[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      op_chg        <= 1'b0;
      op_rem        <= 1'b0;
      launch        <= 1'b0;
      done          <= 1'b0;
      status        <= ST_OK;
      removed_value <= '0;
      key           <= '0;
      new_prio      <= '0;
    end else begin
      done   <= 1'b0;
      launch <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            removed_value <= '0;
            key           <= item_value;
            new_prio      <= item_priority;
            case (req_type)
              REQ_INSERT: begin
                done <= 1'b1;
                if (full) begin
                  status <= ST_FULL;
                end else begin
                  status <= ST_OK;
                  cnt    <= cnt + CNT_W'(1);
                end
              end
              REQ_CHANGE: begin
                launch <= 1'b1;
                op_chg <= 1'b1;
                state  <= S_SCAN;
              end
              REQ_REMOVE: begin
                if (cnt == '0) begin
                  done   <= 1'b1;
                  status <= ST_EMPTY;
                end else begin
                  launch <= 1'b1;
                  op_rem <= 1'b1;
                  state  <= S_SCAN;
                end
              end
              default: begin
                done   <= 1'b1;
                status <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (fin) begin
            done   <= 1'b1;
            state  <= S_IDLE;
            op_chg <= 1'b0;
            op_rem <= 1'b0;
            if (op_rem) begin
              status        <= ST_OK;
              removed_value <= last.best_value;
              cnt           <= cnt - CNT_W'(1);
            end else begin
              status        <= last.found ? ST_OK : ST_NOT_FOUND;
              removed_value <= '0;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_fin_in_scan: assert property (@(posedge clk) disable iff (rst)
    fin |-> (state == S_SCAN))
    else $error("search token finished outside a scan");

  a_rem_found: assert property (@(posedge clk) disable iff (rst)
    (fin && op_rem) |-> last.have)
    else $error("remove finished without a candidate");

  a_rem_count: assert property (@(posedge clk) disable iff (rst)
    (fin && op_rem) |=> (cnt == $past(cnt) - CNT_W'(1)))
    else $error("remove did not shrink the queue");

  a_accept_resp: assert property (@(posedge clk) disable iff (rst)
    accept |=> (done || busy))
    else $error("request neither answered nor in progress");
`endif

endmodule
